### rtl/brn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_pkg
// Shared types and constants for the bilinear resize / normalize unit.
// ----------------------------------------------------------------------------
package brn_pkg;

  // Store geometry
  localparam int PLANE_DEPTH = 16384;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
  localparam int CHANNELS    = 3;
  localparam int CH_W        = 2;
  localparam int STORE_DEPTH = CHANNELS * PLANE_DEPTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int SAMPLE_W    = 8;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 20;

  // Fixed point constants
  localparam int UNITY_Q15 = 32768;
  localparam int HALF_PIX  = 16384;

  // Item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_X_RATIO  = 3'd0,
    REG_Y_RATIO  = 3'd1,
    REG_START    = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_MEAN0    = 3'd4,
    REG_MEAN1    = 3'd5,
    REG_MEAN2    = 3'd6,
    REG_GAIN     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  channel;
    logic [13:0] load_address;
    logic [7:0]  sample_value;
    logic [11:0] out_x;
    logic [11:0] out_y;
  } in_item_t;

  typedef struct packed {
    logic signed [28:0] pixel_out;
    logic               outside_read;
  } out_item_t;

endpackage

### rtl/brn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module brn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/bilinear_resize_normalize_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_unit
// Three 8-bit source planes in one single-port store, bilinear resampling
// of one output pixel per compute item, mean subtraction and gain.
// ----------------------------------------------------------------------------
// A load transfer writes one sample through the store port. A compute
// transfer needs four store reads (one when both ratios are unity), issued
// one per cycle on the single store port. The last read of an item waits
// until the previous item has left the collect register. The sequencer
// takes the next item once the current one has written its sample or issued
// its last read. Items flow through a four-stage address pipeline, the read
// sequencer and a five-stage arithmetic pipeline. Loads and reads reach the
// store in arrival order, so a compute sees every earlier load.
// Configuration must only be written while the unit is empty.
module bilinear_resize_normalize_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  brn_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output brn_pkg::out_item_t         out_data,
  input  logic                       cfg_en,
  input  logic [brn_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [brn_pkg::CFG_DW-1:0] cfg_data
);
  import brn_pkg::*;

  // Configuration registers
  logic [18:0]        x_ratio;
  logic [18:0]        y_ratio;
  logic [13:0]        start_offset;
  logic [14:0]        row_len;
  logic signed [16:0] mean_ch0;
  logic signed [16:0] mean_ch1;
  logic signed [16:0] mean_ch2;
  logic signed [19:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_ratio      <= 19'(UNITY_Q15);
      y_ratio      <= 19'(UNITY_Q15);
      start_offset <= '0;
      row_len      <= 15'd128;
      mean_ch0     <= '0;
      mean_ch1     <= '0;
      mean_ch2     <= '0;
      gain         <= 20'sd65536;
    end else if (cfg_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_X_RATIO: x_ratio      <= cfg_data[18:0];
        REG_Y_RATIO: y_ratio      <= cfg_data[18:0];
        REG_START:   start_offset <= cfg_data[13:0];
        REG_WIDTH:   row_len      <= cfg_data[14:0];
        REG_MEAN0:   mean_ch0     <= $signed(cfg_data[16:0]);
        REG_MEAN1:   mean_ch1     <= $signed(cfg_data[16:0]);
        REG_MEAN2:   mean_ch2     <= $signed(cfg_data[16:0]);
        REG_GAIN:    gain         <= $signed(cfg_data[19:0]);
        default:     gain         <= gain;
      endcase
    end
  end

  logic unity;
  assign unity = (x_ratio == 19'(UNITY_Q15)) && (y_ratio == 19'(UNITY_Q15));

  // Handshake chain
  logic s1_v, s2_v, s3_v, s4_v;
  logic rdy1, rdy2, rdy3, rdy4;
  logic seq_take;
  logic in_go;

  assign rdy4     = !s4_v || seq_take;
  assign rdy3     = !s3_v || rdy4;
  assign rdy2     = !s2_v || rdy3;
  assign rdy1     = !s1_v || rdy2;
  assign in_stall = !rdy1;
  assign in_go    = in_valid && rdy1;

  // Stage 1: capture transfer (out_x/out_y fields are 12 bits, up to 4095)
  in_item_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (rdy1) begin
      s1_v <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1 <= in_data;
    end
  end

  // Stage 2: source coordinates in Q15, row product for the copy path
  in_item_t           s2;
  logic signed [32:0] s2_fx, s2_fy;
  logic [26:0]        s2_uprod;
  logic [30:0]        mx, my;
  always_comb begin
    mx = 31'(s1.out_x) * 31'(x_ratio);
    my = 31'(s1.out_y) * 31'(y_ratio);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (rdy2) begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2       <= s1;
      s2_fx    <= $signed({2'b00, mx}) + $signed({15'd0, x_ratio[18:1]}) - 33'sd16384;
      s2_fy    <= $signed({2'b00, my}) + $signed({15'd0, y_ratio[18:1]}) - 33'sd16384;
      s2_uprod <= 27'(s1.out_y) * 27'(row_len);
    end
  end

  // Stage 3: integer part with clamps, 11-bit weights, copy-path index
  in_item_t           s3;
  logic signed [16:0] s3_sx;
  logic [16:0]        s3_sy;
  logic [10:0]        s3_wx, s3_wy;
  logic [27:0]        s3_uidx;
  logic signed [17:0] sx_raw, sy_raw;
  logic signed [16:0] sx_c;
  logic [16:0]        sy_c;
  logic [15:0]        fxr, fyr;
  always_comb begin
    sx_raw = s2_fx[32:15];
    sy_raw = s2_fy[32:15];
    if (sx_raw < 0) begin
      sx_c = '0;
    end else if (sx_raw > $signed({3'b000, row_len})) begin
      sx_c = $signed({2'b00, row_len}) - 17'sd1;
    end else begin
      sx_c = sx_raw[16:0];
    end
    sy_c = (sy_raw < 0) ? 17'd0 : sy_raw[16:0];
    fxr  = {1'b0, s2_fx[14:0]} + 16'd16;
    fyr  = {1'b0, s2_fy[14:0]} + 16'd16;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (rdy3) begin
      s3_v <= s2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3      <= s2;
      s3_sx   <= sx_c;
      s3_sy   <= sy_c;
      s3_wx   <= fxr[15:5];
      s3_wy   <= fyr[15:5];
      s3_uidx <= 28'(s2.out_x) + 28'(s2_uprod) + 28'(start_offset);
    end
  end

  // Stage 4: base index of the top-left neighbour
  in_item_t           s4;
  logic signed [34:0] s4_base;
  logic [10:0]        s4_wx, s4_wy;
  logic               s4_unity;
  logic [31:0]        yprod;
  assign yprod = 32'(s3_sy) * 32'(row_len);
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (rdy4) begin
      s4_v <= s3_v;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4       <= s3;
      s4_wx    <= s3_wx;
      s4_wy    <= s3_wy;
      s4_unity <= unity;
      if (unity) begin
        s4_base <= $signed({7'd0, s3_uidx});
      end else begin
        s4_base <= $signed({3'b000, yprod}) + 35'(s3_sx) + $signed({21'd0, start_offset});
      end
    end
  end

  // Read sequencer: owns the store port, one access per cycle
  logic               cur_v;
  in_item_t           cur;
  logic signed [34:0] cur_base;
  logic [10:0]        cur_wx, cur_wy;
  logic               cur_unity;
  logic [1:0]         step;
  logic [1:0]         last_step;
  logic               col_v, col_go;
  logic               col_free, issue, cur_done;
  logic signed [34:0] idx;
  logic               idx_zero;
  logic               is_load;
  logic               ram_we, ram_rd;
  logic [STORE_AW-1:0] ram_addr;
  logic [SAMPLE_W-1:0] ram_q;
  logic               rd_v, rd_last, rd_zero;

  // A last read landing this cycle fills the collect register next cycle
  assign is_load   = (cur.mode == MODE_LOAD);
  assign last_step = cur_unity ? 2'd0 : 2'd3;
  assign col_free  = (!col_v || col_go) && !(rd_v && rd_last);
  assign issue     = cur_v && !is_load && ((step != last_step) || col_free);
  assign cur_done  = is_load || (issue && (step == last_step));
  assign seq_take  = !cur_v || cur_done;

  always_comb begin
    idx      = cur_base + (step[1] ? $signed({20'd0, row_len}) : 35'sd0)
               + $signed({34'd0, step[0]});
    idx_zero = (cur.channel >= CH_W'(CHANNELS)) || idx[34] || (idx[33:PLANE_AW] != '0);
    ram_we   = cur_v && is_load && (cur.channel < CH_W'(CHANNELS));
    ram_rd   = issue && !idx_zero;
    ram_addr = is_load ? {cur.channel, cur.load_address} : {cur.channel, idx[PLANE_AW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      step  <= '0;
    end else if (seq_take) begin
      cur_v <= s4_v;
      step  <= '0;
    end else if (issue) begin
      step  <= step + 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (seq_take) begin
      cur       <= s4;
      cur_base  <= s4_base;
      cur_wx    <= s4_wx;
      cur_wy    <= s4_wy;
      cur_unity <= s4_unity;
    end
  end

  brn_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .en    (ram_rd),
    .addr  (ram_addr),
    .wdata (cur.sample_value),
    .rdata (ram_q)
  );

  // Read return tracking
  logic [1:0]  rd_slot;
  logic [10:0] rd_wx, rd_wy;
  logic        rd_unity;
  logic [1:0]  rd_ch;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
    end
  end
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_slot  <= step;
      rd_last  <= (step == last_step);
      rd_zero  <= idx_zero;
      rd_wx    <= cur_wx;
      rd_wy    <= cur_wy;
      rd_unity <= cur_unity;
      rd_ch    <= cur.channel;
    end
  end

  logic [7:0] rd_sample;
  logic [7:0] sa, sb, sc;
  logic       acc_out;
  assign rd_sample = rd_zero ? 8'd0 : ram_q;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      unique case (rd_slot)
        2'd0:    sa <= rd_sample;
        2'd1:    sb <= rd_sample;
        2'd2:    sc <= rd_sample;
        default: sc <= sc;
      endcase
      acc_out <= (rd_slot == 2'd0) ? rd_zero : (acc_out | rd_zero);
    end
  end

  // Collected neighbours, handed to the arithmetic pipeline
  logic       be_en;
  logic [7:0] col_a, col_b, col_c, col_d;
  logic [10:0] col_wx, col_wy;
  logic       col_unity, col_out;
  logic [1:0] col_ch;

  assign be_en  = !out_valid || !out_stall;
  assign col_go = col_v && be_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_v <= 1'b0;
    end else if (rd_v && rd_last) begin
      col_v <= 1'b1;
    end else if (col_go) begin
      col_v <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (rd_v && rd_last) begin
      col_a     <= (rd_slot == 2'd0) ? rd_sample : sa;
      col_b     <= sb;
      col_c     <= sc;
      col_d     <= rd_sample;
      col_wx    <= rd_wx;
      col_wy    <= rd_wy;
      col_unity <= rd_unity;
      col_ch    <= rd_ch;
      col_out   <= (rd_slot == 2'd0) ? rd_zero : (acc_out | rd_zero);
    end
  end

  // B1: horizontal blend of both rows
  logic               b1_v, b1_unity, b1_out;
  logic [1:0]         b1_ch;
  logic [7:0]         b1_a;
  logic [10:0]        b1_wy;
  logic signed [20:0] b1_r1, b1_r2;
  logic signed [8:0]  dab, dcd;
  logic signed [11:0] swx;
  always_comb begin
    dab = $signed({1'b0, col_b}) - $signed({1'b0, col_a});
    dcd = $signed({1'b0, col_d}) - $signed({1'b0, col_c});
    swx = $signed({1'b0, col_wx});
  end

  // B2: vertical blend, round and wrap to 8 bits, or the copied sample on the copy path
  logic               b2_v, b2_out;
  logic [1:0]         b2_ch;
  logic [7:0]         b2_v8;
  logic signed [34:0] tsum;
  always_comb begin
    tsum = 35'($signed({1'b0, b1_wy}) * 35'(b1_r2 - b1_r1)) + (35'(b1_r1) <<< 10)
           + 35'sd524288;
  end

  // B3: mean subtraction in Q.8
  logic               b3_v, b3_out;
  logic signed [17:0] b3_d;
  logic signed [16:0] mean_sel;
  always_comb begin
    unique case (b2_ch)
      2'd0:    mean_sel = mean_ch0;
      2'd1:    mean_sel = mean_ch1;
      2'd2:    mean_sel = mean_ch2;
      default: mean_sel = '0;
    endcase
  end

  // B4: gain
  logic               b4_v, b4_out;
  logic signed [37:0] b4_p;

  // Output: round half up and saturate
  logic signed [38:0] pr;
  logic signed [30:0] q;
  logic signed [28:0] qsat;
  always_comb begin
    pr = 39'(b4_p) + 39'sd128;
    q  = pr[38:8];
    if (q > 31'sd268435455) begin
      qsat = 29'sd268435455;
    end else if (q < -31'sd268435456) begin
      qsat = -29'sd268435456;
    end else begin
      qsat = q[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      b4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (be_en) begin
      b1_v      <= col_v;
      b2_v      <= b1_v;
      b3_v      <= b2_v;
      b4_v      <= b3_v;
      out_valid <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be_en) begin
      b1_r1    <= 21'(swx * 21'(dab)) + 21'($signed({1'b0, col_a, 10'd0}));
      b1_r2    <= 21'(swx * 21'(dcd)) + 21'($signed({1'b0, col_c, 10'd0}));
      b1_a     <= col_a;
      b1_wy    <= col_wy;
      b1_unity <= col_unity;
      b1_ch    <= col_ch;
      b1_out   <= col_out;

      b2_v8    <= b1_unity ? b1_a : tsum[27:20];
      b2_ch    <= b1_ch;
      b2_out   <= b1_out;

      b3_d     <= $signed({2'b00, b2_v8, 8'd0}) - 18'(mean_sel);
      b3_out   <= b2_out;

      b4_p     <= 38'(b3_d) * 38'(gain);
      b4_out   <= b3_out;

      out_data.pixel_out    <= qsat;
      out_data.outside_read <= b4_out;
    end
  end

`ifndef NO_ASSERTIONS
  // Last read data never lands on a collected item that has not moved on
  a_col_free: assert property (@(posedge clk) disable iff (rst)
    (rd_v && rd_last) |-> (!col_v || col_go))
    else $error("collect register overwritten");

  // Store port carries a write or a read, never both
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_rd))
    else $error("store write and read in one cycle");

  // Copy path issues exactly one read
  a_unity_one: assert property (@(posedge clk) disable iff (rst)
    (cur_v && !is_load && cur_unity) |-> (step == 2'd0))
    else $error("copy path stepped past first read");
`endif

endmodule

### sim/bilinear_resize_normalize_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_unit_test
// Self-checking bench for the resize / normalize unit. Every sample that a
// compute will read is loaded ahead of it. Directed and random load and
// compute items run under several register settings. Each compute transfer
// is predicted from a local copy of the planes and registers. Each output
// transfer is checked in order.
// ----------------------------------------------------------------------------
module bilinear_resize_normalize_unit_test;
  import brn_pkg::*;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_en = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_DW-1:0]  cfg_data = '0;

  bilinear_resize_normalize_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_en, .cfg_addr, .cfg_data
  );

  // Local copy of the planes and the register file
  byte unsigned sample_copy [0:STORE_DEPTH-1];
  logic [CFG_DW-1:0] reg_copy [0:7];
  // Entries that some queued load writes
  bit           planned [0:STORE_DEPTH-1];

  in_item_t  pending_items[$];
  out_item_t expected_pixels[$];
  int        idle_pct = 33;
  int        fail_count = 0;
  int        items_queued = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("bilinear_resize_normalize_unit_test failed");
    $finish;
  end

  function automatic longint fetch_sample(int ch, longint idx, inout bit outside);
    if (ch >= CHANNELS || idx < 0 || idx >= PLANE_DEPTH) begin
      outside = 1'b1;
      return 0;
    end
    return longint'(sample_copy[ch * PLANE_DEPTH + idx]);
  endfunction

  // Resample, then subtract the mean and apply the gain
  function automatic out_item_t predict_pixel(in_item_t it);
    longint ox, oy, xr, yr, off, w, fx, fy, sx, sy, base;
    longint a, b, c, d, r1, r2, t, v, mean, g, p;
    bit outside;
    int ch;
    out_item_t res;
    outside = 1'b0;
    ch  = int'(it.channel);
    ox  = longint'(it.out_x);
    oy  = longint'(it.out_y);
    xr  = longint'(reg_copy[REG_X_RATIO][18:0]);
    yr  = longint'(reg_copy[REG_Y_RATIO][18:0]);
    off = longint'(reg_copy[REG_START][13:0]);
    w   = longint'(reg_copy[REG_WIDTH][14:0]);
    if (xr == UNITY_Q15 && yr == UNITY_Q15) begin
      v = fetch_sample(ch, ox + oy * w + off, outside);
    end else begin
      fx = ox * xr + (xr >>> 1) - HALF_PIX;
      fy = oy * yr + (yr >>> 1) - HALF_PIX;
      sx = fx >>> 15;
      sy = fy >>> 15;
      fx = fx - sx * 32768;
      fy = fy - sy * 32768;
      if (sx < 0) sx = 0;
      if (sx > w) sx = w - 1;
      if (sy < 0) sy = 0;
      fx = (fx + 16) >>> 5;
      fy = (fy + 16) >>> 5;
      base = sx + off + sy * w;
      a = fetch_sample(ch, base, outside);
      b = fetch_sample(ch, base + 1, outside);
      c = fetch_sample(ch, base + w, outside);
      d = fetch_sample(ch, base + w + 1, outside);
      r1 = fx * (b - a) + a * 1024;
      r2 = fx * (d - c) + c * 1024;
      t  = fy * (r2 - r1) + r1 * 1024;
      v  = ((t + 524288) >>> 20) & 255;
    end
    mean = 0;
    if (ch < 3) mean = longint'($signed(reg_copy[REG_MEAN0 + ch][16:0]));
    g = longint'($signed(reg_copy[REG_GAIN][19:0]));
    p = (v * 256 - mean) * g;
    p = (p + 128) >>> 8;
    if (p > 268435455) p = 268435455;
    if (p < -268435456) p = -268435456;
    res.pixel_out    = p[28:0];
    res.outside_read = outside;
    return res;
  endfunction

  // Queue one item; a load marks its entry as written
  function automatic void queue_item(in_item_t it);
    if (it.mode == MODE_LOAD && int'(it.channel) < CHANNELS)
      planned[int'(it.channel) * PLANE_DEPTH + int'(it.load_address)] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // Load an entry with a random sample unless a queued load already wrote it
  function automatic void cover_entry(int ch, longint idx);
    in_item_t ld;
    ld = '0;
    if (ch < CHANNELS && idx >= 0 && idx < PLANE_DEPTH) begin
      if (!planned[ch * PLANE_DEPTH + int'(idx)]) begin
        ld.mode         = MODE_LOAD;
        ld.channel      = CH_W'(ch);
        ld.load_address = PLANE_AW'(idx);
        ld.sample_value = 8'($urandom_range(255));
        queue_item(ld);
      end
    end
  endfunction

  // Make sure every in-plane entry a compute reads has been loaded first
  function automatic void cover_reads(in_item_t it);
    longint ox, oy, xr, yr, off, w, fx, fy, sx, sy, base;
    int ch;
    ch  = int'(it.channel);
    ox  = longint'(it.out_x);
    oy  = longint'(it.out_y);
    xr  = longint'(reg_copy[REG_X_RATIO][18:0]);
    yr  = longint'(reg_copy[REG_Y_RATIO][18:0]);
    off = longint'(reg_copy[REG_START][13:0]);
    w   = longint'(reg_copy[REG_WIDTH][14:0]);
    if (xr == UNITY_Q15 && yr == UNITY_Q15) begin
      cover_entry(ch, ox + oy * w + off);
    end else begin
      fx = ox * xr + (xr >>> 1) - HALF_PIX;
      fy = oy * yr + (yr >>> 1) - HALF_PIX;
      sx = fx >>> 15;
      sy = fy >>> 15;
      if (sx < 0) sx = 0;
      if (sx > w) sx = w - 1;
      if (sy < 0) sy = 0;
      base = sx + off + sy * w;
      cover_entry(ch, base);
      cover_entry(ch, base + 1);
      cover_entry(ch, base + w);
      cover_entry(ch, base + w + 1);
    end
  endfunction

  // Input driver: loads update the plane copy, computes queue a prediction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_LOAD) begin
          if (int'(in_data.channel) < CHANNELS)
            sample_copy[int'(in_data.channel) * PLANE_DEPTH + int'(in_data.load_address)] =
              in_data.sample_value;
        end else begin
          expected_pixels.push_back(predict_pixel(in_data));
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random stalls
  always @(posedge clk) begin
    out_item_t exp_px;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, out_data);
        fail_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_data.pixel_out !== exp_px.pixel_out) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   exp_px.pixel_out, out_data.pixel_out);
          fail_count++;
        end
        if (out_data.outside_read !== exp_px.outside_read) begin
          $display("%0t: outside_read expected %0b actual %0b", $time,
                   exp_px.outside_read, out_data.outside_read);
          fail_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic write_reg(cfg_reg_t r, int value);
    @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_addr <= r;
    cfg_data <= value[CFG_DW-1:0];
    reg_copy[r] = value[CFG_DW-1:0];
  endtask

  task automatic write_all(int xr, int yr, int off, int w, int m0, int m1, int m2, int g);
    write_reg(REG_X_RATIO, xr);
    write_reg(REG_Y_RATIO, yr);
    write_reg(REG_START, off);
    write_reg(REG_WIDTH, w);
    write_reg(REG_MEAN0, m0);
    write_reg(REG_MEAN1, m1);
    write_reg(REG_MEAN2, m2);
    write_reg(REG_GAIN, g);
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Wait until all items are sent and all results are back, then let loads settle
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_compute(int ch, int x, int y);
    in_item_t it;
    it = '0;
    it.mode = MODE_COMPUTE;
    it.channel = CH_W'(ch);
    it.out_x = 12'(x);
    it.out_y = 12'(y);
    cover_reads(it);
    queue_item(it);
  endtask

  // Random mix of about n items: a quarter loads, mostly small coordinates
  task automatic add_random(int n);
    in_item_t it;
    int first;
    first = items_queued;
    while (items_queued - first < n) begin
      it.mode = ($urandom_range(3) == 0) ? MODE_LOAD : MODE_COMPUTE;
      it.channel = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
      it.load_address = 14'($urandom_range(16383));
      it.sample_value = 8'($urandom_range(255));
      it.out_x = ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) :
                                            12'($urandom_range(63));
      it.out_y = ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) :
                                            12'($urandom_range(63));
      if (it.mode == MODE_COMPUTE)
        cover_reads(it);
      queue_item(it);
    end
  endtask

  initial begin
    in_item_t it;
    reg_copy[REG_X_RATIO] = CFG_DW'(32768);
    reg_copy[REG_Y_RATIO] = CFG_DW'(32768);
    reg_copy[REG_START]   = '0;
    reg_copy[REG_WIDTH]   = CFG_DW'(128);
    reg_copy[REG_MEAN0]   = '0;
    reg_copy[REG_MEAN1]   = '0;
    reg_copy[REG_MEAN2]   = '0;
    reg_copy[REG_GAIN]    = CFG_DW'(65536);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Load to a missing channel is dropped
    it = '0;
    it.mode = MODE_LOAD;
    it.channel = 2'd3;
    it.load_address = 14'd16383;
    it.sample_value = 8'hff;
    queue_item(it);
    // Copy path at reset settings: corners, far coordinates, missing channel
    add_compute(0, 0, 0);
    add_compute(1, 127, 0);
    add_compute(2, 4095, 4095);
    add_compute(3, 5, 5);
    add_compute(0, 4095, 0);
    add_compute(1, 0, 127);
    add_random(150);
    wait_drained();

    // Copy path, extreme means, no idling at all
    idle_pct = 0;
    write_all(32768, 32768, 16383, 128, 65535, -65536, 12345, 65536);
    add_compute(0, 0, 0);
    add_compute(1, 0, 0);
    add_compute(2, 4095, 4095);
    add_random(200);
    wait_drained();
    idle_pct = 33;

    // Downscale by two with a crop offset
    write_all(65536, 65536, 300, 64, 128 * 256, -300, 0, 131072);
    add_compute(0, 0, 0);
    add_compute(1, 4095, 0);
    add_compute(2, 0, 4095);
    add_compute(3, 10, 10);
    add_random(200);
    wait_drained();

    // Smallest ratios, widest rows, largest offset
    write_all(1, 1, 16383, 16384, -1, 1, 0, 65536);
    add_compute(0, 0, 0);
    add_compute(1, 4095, 4095);
    add_random(150);
    wait_drained();

    // Ratios of eight, most negative mean and gain
    write_all(262144, 262144, 0, 16, -65536, -65536, -65536, -524288);
    add_compute(0, 0, 0);
    add_compute(2, 4095, 4095);
    add_random(150);
    wait_drained();

    // Upscale, largest gain to force saturation both ways
    write_all(16384, 24576, 7, 100, 65535, -65536, 256, 524287);
    add_random(170);
    wait_drained();

    // Zero row length, one ratio unity
    write_all(32768, 49152, 50, 0, 0, 0, 0, 65536);
    add_random(150);
    wait_drained();

    // Column clamp at the row length
    write_all(98304, 40000, 0, 3, 1000, -1000, 77, -65536);
    add_compute(0, 4095, 2);
    add_compute(1, 1, 1);
    add_random(150);
    wait_drained();

    // Random settings
    repeat (3) begin
      write_all($urandom_range(262143) + 1, $urandom_range(262143) + 1,
                $urandom_range(16383), $urandom_range(16383) + 1,
                $urandom_range(131071), $urandom_range(131071),
                $urandom_range(131071), $urandom_range(1048575));
      add_random(80);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("bilinear_resize_normalize_unit_test passed");
    end else begin
      $display("bilinear_resize_normalize_unit_test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/brn_pkg.sv
rtl/brn_ram.sv
rtl/bilinear_resize_normalize_unit.sv
sim/bilinear_resize_normalize_unit_test.sv
